// File: sv/cac_pkg.sv
// Shared types, codes and constants for the coil alignment classifier.
// Used by the controller, the datapath and the top level; no dependencies.
package cac_pkg;

	localparam int CODE_BITS_DEF = 8;   // default width of a raw register code
	localparam int IN_CODE_W     = 8;   // width of a code field on the request port
	localparam int FREQ_W        = 15;
	localparam int CURR_W        = 11;
	localparam int MARGIN_W      = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 15;

	localparam logic [FREQ_W-1:0] FREQ_NUMERATOR = 15'd16384;
	localparam int unsigned       CURR_SCALE     = 1800;
	localparam int                CURR_SHIFT     = 8;
	localparam logic [CURR_W-1:0] CURR_MAX       = 11'd2047;

	// Request types.
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_STOP   = 2'd2;

	// Alignment levels.
	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_ONE  = 2'd1;
	localparam logic [1:0] LVL_TWO  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CURR_W-1:0]   RST_CURRENT_SPLIT = 11'd512;
	localparam logic [FREQ_W-1:0]   RST_TH_LOW        = 15'd157;
	localparam logic [FREQ_W-1:0]   RST_TH_HIGH       = 15'd147;
	localparam logic [MARGIN_W-1:0] RST_MARGIN        = 8'd3;
	localparam logic [FREQ_W-1:0]   RST_MIN_FREQ      = 15'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CURRENT_SPLIT  = 3'd0,
		CFG_TH_LOW         = 3'd1,
		CFG_TH_HIGH        = 3'd2,
		CFG_RISE_LOW       = 3'd3,
		CFG_FALL_LOW       = 3'd4,
		CFG_RISE_HIGH      = 3'd5,
		CFG_FALL_HIGH      = 3'd6,
		CFG_MIN_FREQ       = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [IN_CODE_W-1:0] freq_code;
		logic                 freq_read_ok;
		logic [IN_CODE_W-1:0] current_code;
		logic                 current_read_ok;
	} cac_in_t;

	typedef struct packed {
		logic              status;
		logic [1:0]        alignment_level;
		logic [FREQ_W-1:0] frequency_value;
		logic [CURR_W-1:0] current_value;
	} cac_out_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic classify;
		logic emit;
	} cac_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic skip;      // stop request, failed read or zero code: no division needed
		logic out_free;  // the result register can take a new result this cycle
	} cac_stat_t;

endpackage

// File: sv/coil_alignment_classifier.sv
// Top level of the coil alignment classifier: joins controller and datapath.
// Depends on cac_pkg, cac_ctrl and cac_dpath.
//
//   port group   direction  handshake              payload
//   request      in         in_valid / in_ready    in_data   (cac_in_t)
//   result       out        out_valid / out_ready  out_data  (cac_out_t)
//   config       in         cfg_wr_en              cfg_index, cfg_data
//
// A sample request runs from acceptance through decode, the restoring divider,
// which produces one bit of the 16384 / code quotient per cycle, then
// classify and hand-off before the next request is accepted.
// Stop requests and failed reads skip the divider and the classify step.
// Reset clears the level to not connected and loads the register defaults.
// A stalled result waits in the result register; the block then holds the
// next finished result until that register is free.
module coil_alignment_classifier #(
	parameter int CODE_BITS = cac_pkg::CODE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  cac_pkg::cac_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cac_pkg::cac_out_t              out_data,
	input  logic                           cfg_wr_en,
	input  cac_pkg::cfg_idx_t              cfg_index,
	input  logic [cac_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cac_pkg::*;

	cac_cmd_t  cmd;
	cac_stat_t stat;

	cac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	cac_dpath #(
		.CODE_BITS (CODE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: sv/cac_ctrl.sv
// Controller of the coil alignment classifier: sequences load, division,
// classification and result hand-off. Depends on cac_pkg.
module cac_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output cac_pkg::cac_cmd_t   cmd,
	input  cac_pkg::cac_stat_t  stat
);
	import cac_pkg::*;

	localparam int DIV_STEPS = FREQ_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_CLASSIFY,
		ST_RESULT
	} state_t;

	state_t           state_q;
	logic             in_ready_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready = in_ready_q;

	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && in_valid && in_ready_q;
		cmd.div_step = (state_q == ST_DIVIDE) && !stat.skip;
		cmd.classify = (state_q == ST_CLASSIFY);
		cmd.emit     = (state_q == ST_RESULT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
			cnt_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_DIVIDE;
						in_ready_q <= 1'b0;
						cnt_q      <= '0;
					end
				end
				ST_DIVIDE: begin
					if (stat.skip) begin
						state_q <= ST_RESULT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
							state_q <= ST_CLASSIFY;
						end
					end
				end
				ST_CLASSIFY: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (stat.out_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/cac_dpath.sv
// Datapath of the coil alignment classifier: configuration registers,
// current scaling, bit-serial reciprocal divider, level register and result
// register. Depends on cac_pkg.
module cac_dpath #(
	parameter int CODE_BITS = cac_pkg::CODE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cac_pkg::cac_cmd_t                   cmd,
	output cac_pkg::cac_stat_t                  stat,
	input  cac_pkg::cac_in_t                    in_data,
	input  logic                                cfg_wr_en,
	input  cac_pkg::cfg_idx_t                   cfg_index,
	input  logic [cac_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cac_pkg::cac_out_t                   out_data
);
	import cac_pkg::*;

	localparam int PROD_W = CODE_BITS + CURR_W;

	// Configuration.
	logic [CURR_W-1:0]   split_q;
	logic [FREQ_W-1:0]   th_low_q, th_high_q, min_freq_q;
	logic [MARGIN_W-1:0] rise_low_q, fall_low_q, rise_high_q, fall_high_q;

	// Request held for the duration of the work.
	logic                 stop_q, bad_q;
	logic [CODE_BITS-1:0] fcode_q;
	logic [CURR_W-1:0]    curr_q;
	logic [CODE_BITS-1:0] rem_q;
	logic [FREQ_W-1:0]    quo_q;
	logic [1:0]           level_q;

	cac_out_t out_q;
	logic     out_valid_q;

	logic [CODE_BITS-1:0] fcode_in, ccode_in;
	logic                 bad_in;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    scaled;
	logic [CURR_W-1:0]    curr_in;

	logic [CODE_BITS:0]   trial, diff;
	logic                 fits;

	logic                low_sel;
	logic [FREQ_W-1:0]   th;
	logic [MARGIN_W-1:0] up, dn;
	logic [FREQ_W:0]     th_up, freq_dn;
	logic [1:0]          level_nx;

	assign fcode_in = CODE_BITS'(in_data.freq_code);
	assign ccode_in = CODE_BITS'(in_data.current_code);
	assign bad_in   = !in_data.freq_read_ok || (fcode_in == '0) ||
	                  !in_data.current_read_ok || (ccode_in == '0);

	assign prod    = PROD_W'(ccode_in) * PROD_W'(CURR_SCALE);
	assign scaled  = prod >> CURR_SHIFT;
	assign curr_in = (scaled > PROD_W'(CURR_MAX)) ? CURR_MAX : CURR_W'(scaled);

	// One restoring step: bring down the next dividend bit and try the divisor.
	assign trial = {rem_q, quo_q[FREQ_W-1]};
	assign diff  = trial - {1'b0, fcode_q};
	assign fits  = (trial >= {1'b0, fcode_q});

	always_comb begin
		low_sel = (curr_q < split_q);
		th      = low_sel ? th_low_q   : th_high_q;
		up      = low_sel ? rise_low_q : rise_high_q;
		dn      = low_sel ? fall_low_q : fall_high_q;
		th_up   = {1'b0, th} + (FREQ_W + 1)'(up);
		// Testing freq + down against th avoids a negative threshold.
		freq_dn = {1'b0, quo_q} + (FREQ_W + 1)'(dn);
		unique case (level_q)
			LVL_NONE: begin
				if (quo_q > th) begin
					level_nx = LVL_TWO;
				end else if (quo_q > min_freq_q) begin
					level_nx = LVL_ONE;
				end else begin
					level_nx = LVL_NONE;
				end
			end
			LVL_ONE: begin
				if ({1'b0, quo_q} > th_up) begin
					level_nx = LVL_TWO;
				end else if (quo_q < min_freq_q) begin
					level_nx = LVL_NONE;
				end else begin
					level_nx = LVL_ONE;
				end
			end
			LVL_TWO: begin
				if (quo_q < min_freq_q) begin
					level_nx = LVL_NONE;
				end else if (freq_dn <= {1'b0, th}) begin
					level_nx = LVL_ONE;
				end else begin
					level_nx = LVL_TWO;
				end
			end
			default: begin
				level_nx = level_q;
			end
		endcase
	end

	assign stat.skip     = stop_q || bad_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q     <= RST_CURRENT_SPLIT;
			th_low_q    <= RST_TH_LOW;
			th_high_q   <= RST_TH_HIGH;
			rise_low_q  <= RST_MARGIN;
			fall_low_q  <= RST_MARGIN;
			rise_high_q <= RST_MARGIN;
			fall_high_q <= RST_MARGIN;
			min_freq_q  <= RST_MIN_FREQ;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CURRENT_SPLIT: split_q     <= cfg_data[CURR_W-1:0];
				CFG_TH_LOW:        th_low_q    <= cfg_data[FREQ_W-1:0];
				CFG_TH_HIGH:       th_high_q   <= cfg_data[FREQ_W-1:0];
				CFG_RISE_LOW:      rise_low_q  <= cfg_data[MARGIN_W-1:0];
				CFG_FALL_LOW:      fall_low_q  <= cfg_data[MARGIN_W-1:0];
				CFG_RISE_HIGH:     rise_high_q <= cfg_data[MARGIN_W-1:0];
				CFG_FALL_HIGH:     fall_high_q <= cfg_data[MARGIN_W-1:0];
				CFG_MIN_FREQ:      min_freq_q  <= cfg_data[FREQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LVL_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if ((in_data.req_type == REQ_START) || (in_data.req_type == REQ_STOP)) begin
					level_q <= LVL_NONE;
				end
			end else if (cmd.classify) begin
				level_q <= level_nx;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stop_q  <= (in_data.req_type == REQ_STOP);
			bad_q   <= bad_in;
			fcode_q <= fcode_in;
			curr_q  <= curr_in;
			rem_q   <= '0;
			quo_q   <= FREQ_NUMERATOR;
		end else if (cmd.div_step) begin
			rem_q <= fits ? diff[CODE_BITS-1:0] : trial[CODE_BITS-1:0];
			quo_q <= {quo_q[FREQ_W-2:0], fits};
		end
		if (cmd.emit) begin
			out_q.status          <= bad_q && !stop_q;
			out_q.alignment_level <= level_q;
			out_q.frequency_value <= stat.skip ? '0 : quo_q;
			out_q.current_value   <= stat.skip ? '0 : curr_q;
		end
	end

endmodule

// File: dv/tb_coil_alignment_classifier.sv
// Self-checking testbench for coil_alignment_classifier: random requests with a
// built-in predictor of the alignment levels, over several register settings.
// Depends on cac_pkg and the RTL of the block; nothing else.
module tb_coil_alignment_classifier;
	timeunit 1ns;
	timeprecision 1ps;
	import cac_pkg::*;

	localparam logic [1:0] REQ_SPARE = 2'd3;  // unused request code, acts as a sample
	localparam int HOLD_AT_RESULT    = 300;
	localparam int HOLD_CYCLES       = 400;
	localparam int WATCHDOG_LIMIT    = 4000;
	localparam int DRAIN_CYCLES      = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	cac_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	cac_out_t              out_data;
	logic                  cfg_wr_en = 1'b0;
	cfg_idx_t              cfg_index = CFG_CURRENT_SPLIT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cac_in_t     request_queue[$];
	cac_out_t    expected_results[$];
	int unsigned cfg_model [8];
	logic [1:0]  level_q = LVL_NONE;
	bit          calm = 1'b0;

	int n_accepted = 0, n_start = 0, n_stop = 0, n_invalid = 0;
	int n_results = 0, n_errors = 0, n_settings = 0;
	int send_gap = 0, stall_left = 0, hold_left = 0, idle_cycles = 0;
	bit hold_done = 1'b0;

	coil_alignment_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// Expected result of one request; moves the predicted alignment level.
	function automatic cac_out_t classify_request(cac_in_t rq);
		cac_out_t r;
		int       f, c, th, up, dn, fmin;
		r = '0;
		if (rq.req_type == REQ_START || rq.req_type == REQ_STOP)
			level_q = LVL_NONE;
		if (rq.req_type == REQ_STOP)
			return r;
		if (!rq.freq_read_ok || rq.freq_code == 0 || !rq.current_read_ok ||
				rq.current_code == 0) begin
			r.status = 1'b1;
			r.alignment_level = level_q;
			return r;
		end
		f = 16384 / int'(rq.freq_code);
		c = (int'(rq.current_code) * 1800) / 256;
		if (c < int'(cfg_model[CFG_CURRENT_SPLIT])) begin
			th = cfg_model[CFG_TH_LOW];
			up = cfg_model[CFG_RISE_LOW];
			dn = cfg_model[CFG_FALL_LOW];
		end else begin
			th = cfg_model[CFG_TH_HIGH];
			up = cfg_model[CFG_RISE_HIGH];
			dn = cfg_model[CFG_FALL_HIGH];
		end
		fmin = cfg_model[CFG_MIN_FREQ];
		case (level_q)
			LVL_NONE: begin
				if (f > th) level_q = LVL_TWO;
				else if (f > fmin) level_q = LVL_ONE;
			end
			LVL_ONE: begin
				if (f > th + up) level_q = LVL_TWO;
				else if (f < fmin) level_q = LVL_NONE;
			end
			LVL_TWO: begin
				if (f < fmin) level_q = LVL_NONE;
				else if (f <= th - dn) level_q = LVL_ONE;
			end
			default: ;
		endcase
		r.alignment_level = level_q;
		r.frequency_value = FREQ_W'(f);
		r.current_value = CURR_W'(c);
		return r;
	endfunction

	function automatic cac_in_t make_req(logic [1:0] rt, int fc, bit fok, int cc, bit cok);
		cac_in_t r;
		r.req_type = rt;
		r.freq_code = IN_CODE_W'(fc);
		r.freq_read_ok = fok;
		r.current_code = IN_CODE_W'(cc);
		r.current_read_ok = cok;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one; none at all in a calm phase.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(30, 60);
	endfunction

	// Frequency code, mostly one whose quotient lands close to one of the decision points; else random or zero.
	function automatic int near_freq_code();
		int r, tgt, code;
		r = $urandom_range(0, 99);
		if (r < 4) return 0;
		if (r < 40) return $urandom_range(1, 255);
		case ($urandom_range(0, 6))
			0: tgt = cfg_model[CFG_TH_LOW];
			1: tgt = cfg_model[CFG_TH_HIGH];
			2: tgt = cfg_model[CFG_TH_LOW] + cfg_model[CFG_RISE_LOW];
			3: tgt = cfg_model[CFG_TH_HIGH] + cfg_model[CFG_RISE_HIGH];
			4: tgt = int'(cfg_model[CFG_TH_LOW]) - int'(cfg_model[CFG_FALL_LOW]);
			5: tgt = int'(cfg_model[CFG_TH_HIGH]) - int'(cfg_model[CFG_FALL_HIGH]);
			default: tgt = cfg_model[CFG_MIN_FREQ];
		endcase
		tgt += int'($urandom_range(0, 6)) - 3;
		if (tgt <= 64) return 255;
		code = 16384 / tgt + int'($urandom_range(0, 2)) - 1;
		return (code < 1) ? 1 : (code > 255) ? 255 : code;
	endfunction

	function automatic int near_curr_code();
		int r, code;
		r = $urandom_range(0, 99);
		if (r < 4) return 0;
		if (r < 50) return $urandom_range(1, 255);
		code = int'(cfg_model[CFG_CURRENT_SPLIT]) * 256 / 1800 + int'($urandom_range(0, 4)) - 2;
		return (code < 1) ? 1 : (code > 255) ? 255 : code;
	endfunction

	// Sessions that mostly open with a start, followed by samples, sometimes closed
	// by a stop, with fully random requests mixed in.
	task automatic queue_sessions(int n_items);
		int target, k;
		target = request_queue.size() + n_items;
		while (request_queue.size() < target) begin
			if ($urandom_range(0, 9) == 0) begin
				request_queue.push_back(make_req(2'($urandom_range(0, 3)),
					$urandom_range(0, 255), 1'($urandom_range(0, 1)),
					$urandom_range(0, 255), 1'($urandom_range(0, 1))));
			end else begin
				request_queue.push_back(make_req(($urandom_range(0, 9) < 8) ? REQ_START : REQ_SAMPLE,
					near_freq_code(), 1'b1, near_curr_code(), 1'b1));
				k = $urandom_range(2, 12);
				repeat (k)
					request_queue.push_back(make_req(
						($urandom_range(0, 9) == 0) ? REQ_SPARE : REQ_SAMPLE,
						near_freq_code(), $urandom_range(0, 19) != 0,
						near_curr_code(), $urandom_range(0, 19) != 0));
				if ($urandom_range(0, 9) == 0)
					request_queue.push_back(make_req(REQ_STOP, $urandom_range(0, 255),
						1'($urandom_range(0, 1)), $urandom_range(0, 255),
						1'($urandom_range(0, 1))));
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (request_queue.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		cfg_model[idx] = val;
	endtask

	// Registers change only once every outstanding result has come back.
	task automatic run_phase(int unsigned split, thl, thh, rl, fl, rh, fh, fmin,
			int n_items, bit no_idle);
		wait_drained();
		write_reg(CFG_CURRENT_SPLIT, split);
		write_reg(CFG_TH_LOW, thl);
		write_reg(CFG_TH_HIGH, thh);
		write_reg(CFG_RISE_LOW, rl);
		write_reg(CFG_FALL_LOW, fl);
		write_reg(CFG_RISE_HIGH, rh);
		write_reg(CFG_FALL_HIGH, fh);
		write_reg(CFG_MIN_FREQ, fmin);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
		calm = no_idle;
		queue_sessions(n_items);
	endtask

	task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		$display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, name, exp_v, got_v);
		n_errors++;
	endtask

	// Request driver: predicts each request as it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(classify_request(in_data));
				n_accepted++;
				if (in_data.req_type == REQ_START) n_start++;
				if (in_data.req_type == REQ_STOP) n_stop++;
				else if (!in_data.freq_read_ok || in_data.freq_code == 0 ||
						!in_data.current_read_ok || in_data.current_code == 0)
					n_invalid++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					in_data <= request_queue.pop_front();
					in_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor; once in the run it holds off long enough to back up the block.
	always @(posedge clk) begin
		cac_out_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $realtime, out_data);
					n_errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (out_data.status !== exp_r.status)
						report_field("status", 32'(exp_r.status), 32'(out_data.status));
					if (out_data.alignment_level !== exp_r.alignment_level)
						report_field("alignment_level", 32'(exp_r.alignment_level),
							32'(out_data.alignment_level));
					if (out_data.frequency_value !== exp_r.frequency_value)
						report_field("frequency_value", 32'(exp_r.frequency_value),
							32'(out_data.frequency_value));
					if (out_data.current_value !== exp_r.current_value)
						report_field("current_value", 32'(exp_r.current_value),
							32'(out_data.current_value));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && n_results >= HOLD_AT_RESULT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results outstanding",
					$realtime, idle_cycles, expected_results.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		cfg_model[CFG_CURRENT_SPLIT] = 32'(RST_CURRENT_SPLIT);
		cfg_model[CFG_TH_LOW] = 32'(RST_TH_LOW);
		cfg_model[CFG_TH_HIGH] = 32'(RST_TH_HIGH);
		cfg_model[CFG_RISE_LOW] = 32'(RST_MARGIN);
		cfg_model[CFG_FALL_LOW] = 32'(RST_MARGIN);
		cfg_model[CFG_RISE_HIGH] = 32'(RST_MARGIN);
		cfg_model[CFG_FALL_HIGH] = 32'(RST_MARGIN);
		cfg_model[CFG_MIN_FREQ] = 32'(RST_MIN_FREQ);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk through the levels under the reset settings.
		request_queue.push_back(make_req(REQ_STOP, 0, 1'b0, 0, 1'b0));
		request_queue.push_back(make_req(REQ_SAMPLE, 1, 1'b1, 255, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 255, 1'b1, 255, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 163, 1'b1, 1, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 162, 1'b1, 1, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 102, 1'b1, 1, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 101, 1'b1, 1, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 106, 1'b1, 1, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 1, 1'b1, 1, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 105, 1'b1, 1, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 105, 1'b0, 1, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 0, 1'b1, 1, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 105, 1'b1, 50, 1'b0));
		request_queue.push_back(make_req(REQ_SAMPLE, 105, 1'b1, 0, 1'b1));
		request_queue.push_back(make_req(REQ_SPARE, 110, 1'b1, 72, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 111, 1'b1, 73, 1'b1));
		request_queue.push_back(make_req(REQ_START, 0, 1'b0, 0, 1'b0));
		request_queue.push_back(make_req(REQ_START, 120, 1'b1, 100, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 164, 1'b1, 73, 1'b1));
		request_queue.push_back(make_req(REQ_STOP, 255, 1'b1, 255, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 170, 1'b1, 200, 1'b1));
		request_queue.push_back(make_req(REQ_SPARE, 255, 1'b1, 255, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 85, 1'b1, 170, 1'b1));
		request_queue.push_back(make_req(REQ_SAMPLE, 170, 1'b1, 85, 1'b1));

		run_phase($urandom_range(0, 2047), $urandom_range(64, 400), $urandom_range(64, 400),
			$urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
			$urandom_range(0, 40), $urandom_range(64, 200), 240, 1'b0);
		run_phase(0, 0, 0, 0, 0, 0, 0, 0, 180, 1'b0);
		run_phase(2047, 16384, 16384, 255, 255, 255, 255, 16384, 180, 1'b0);
		// Thresholds below the fall margins, so the level two exit point is negative.
		run_phase(600, 10, 20, 255, 255, 255, 255, 0, 220, 1'b0);
		run_phase(300, 100, 120, 10, 10, 10, 10, 300, 200, 1'b0);
		run_phase(32'(RST_CURRENT_SPLIT), 32'(RST_TH_LOW), 32'(RST_TH_HIGH),
			32'(RST_MARGIN), 32'(RST_MARGIN), 32'(RST_MARGIN), 32'(RST_MARGIN),
			32'(RST_MIN_FREQ), 240, 1'b1);
		run_phase($urandom_range(0, 2047), $urandom_range(0, 16384), $urandom_range(0, 16384),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 16384), 200, 1'b0);
		run_phase($urandom_range(0, 2047), $urandom_range(64, 400), $urandom_range(64, 400),
			$urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
			$urandom_range(0, 40), $urandom_range(64, 200), 240, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $realtime,
				expected_results.size());
			n_errors++;
		end
		$display("Checked %0d results for %0d requests (%0d start, %0d stop, %0d bad reads).",
			n_results, n_accepted, n_start, n_stop, n_invalid);
		$display("Register settings used: %0d besides reset; mismatches: %0d.",
			n_settings, n_errors);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
